FILE: rtl/core/foc_pkg.sv
// ----------------------------------------------------------------------------
// foc_pkg
// Types, register indexes and constants of the field-oriented current loop:
// sequencer states, CORDIC arctangent table and sector boundaries.
// ----------------------------------------------------------------------------
package foc_pkg;

   // sequencer states
   typedef enum logic [5:0] {
      ST_IDLE, ST_ROT_INIT, ST_ROT_ITER, ST_ROT_DONE,
      ST_BETA_A, ST_BETA_B, ST_BETA_S, ST_BETA_F,
      ST_IQ_A, ST_IQ_B, ST_IQ_S, ST_IQ_F,
      ST_PI_E, ST_PI_A, ST_PI_B, ST_PI_S, ST_PI_F,
      ST_UA_A, ST_UA_B, ST_UA_S, ST_UA_F,
      ST_UB_A, ST_UB_B, ST_UB_S, ST_UB_F,
      ST_VEC_INIT, ST_VEC_ITER,
      ST_MAG_A, ST_MAG_B, ST_MAG_S, ST_MAG_F,
      ST_ON_K, ST_ON_A, ST_ON_B, ST_ON_S, ST_ON_C, ST_ON_D,
      ST_FIN
   } foc_state_type;

   // which sin/cos the rotator is working on
   typedef enum logic [1:0] {
      JOB_ANG, JOB_SA, JOB_SB
   } foc_job_type;

   // register indexes
   localparam logic [3:0] REG_PROP_GAIN     = 4'd0;
   localparam logic [3:0] REG_INTEG_GAIN    = 4'd1;
   localparam logic [3:0] REG_INTEG_LOW     = 4'd2;
   localparam logic [3:0] REG_INTEG_HIGH    = 4'd3;
   localparam logic [3:0] REG_DRIVE_LOW     = 4'd4;
   localparam logic [3:0] REG_DRIVE_HIGH    = 4'd5;
   localparam logic [3:0] REG_IQ_TARGET     = 4'd6;
   localparam logic [3:0] REG_D_VOLTAGE     = 4'd7;

   // register reset values
   localparam logic [15:0]        RST_PROP_GAIN  = 16'd1024;
   localparam logic [15:0]        RST_INTEG_GAIN = 16'd256;
   localparam logic signed [15:0] RST_LOW_LIMIT  = -16'sd32768;
   localparam logic signed [15:0] RST_HIGH_LIMIT = 16'sd32767;

   // fixed-point constants
   localparam int                 ATAN_COUNT     = 24;
   localparam logic signed [33:0] GAIN_Q30       = 34'sd652032874;
   localparam logic signed [17:0] K_INV_SQRT3    = 18'sd18919;
   localparam logic signed [17:0] K_TWO_INV_SQRT3 = 18'sd37837;
   localparam logic signed [17:0] K_SQRT3        = 18'sd56756;
   localparam logic signed [63:0] VOLT_LIMIT     = 64'sd309962566;
   localparam logic [31:0]        SECTOR_WIDTH   = 32'd715827883;

   // arctangent of 2^-i, 2^32 per turn
   function automatic logic [31:0] atan_angle(input logic [4:0] idx);
      logic [31:0] a;
      unique case (idx)
         5'd0:  a = 32'd536870912;
         5'd1:  a = 32'd316933406;
         5'd2:  a = 32'd167458907;
         5'd3:  a = 32'd85004756;
         5'd4:  a = 32'd42667331;
         5'd5:  a = 32'd21354465;
         5'd6:  a = 32'd10679838;
         5'd7:  a = 32'd5340245;
         5'd8:  a = 32'd2670163;
         5'd9:  a = 32'd1335087;
         5'd10: a = 32'd667544;
         5'd11: a = 32'd333772;
         5'd12: a = 32'd166886;
         5'd13: a = 32'd83443;
         5'd14: a = 32'd41722;
         5'd15: a = 32'd20861;
         5'd16: a = 32'd10430;
         5'd17: a = 32'd5215;
         5'd18: a = 32'd2608;
         5'd19: a = 32'd1304;
         5'd20: a = 32'd652;
         5'd21: a = 32'd326;
         5'd22: a = 32'd163;
         5'd23: a = 32'd81;
         default: a = 32'd0;
      endcase
      return a;
   endfunction

   // start angle of each sector
   function automatic logic [31:0] sector_start(input logic [2:0] sec);
      logic [31:0] a;
      unique case (sec)
         3'd0: a = 32'd0;
         3'd1: a = 32'd715827883;
         3'd2: a = 32'd1431655765;
         3'd3: a = 32'd2147483648;
         3'd4: a = 32'd2863311531;
         3'd5: a = 32'd3579139413;
         default: a = 32'd0;
      endcase
      return a;
   endfunction

endpackage

FILE: rtl/core/foc_current_loop_svpwm.sv
// ----------------------------------------------------------------------------
// foc_current_loop_svpwm
// Field-oriented current loop with PI regulator and space-vector PWM.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel: one item per PWM period with phase A/B currents and the
//   rotor angle. An item is taken when req_valid is high and req_stall low.
//   req_stall is high while an item is being worked on.
//   rsp_ channel: three compare counts, sector, Iq and Uq of the item.
//   csr_ channel: register writes, always ready; write only when idle.
//   The CORDIC shift-add unit is shared and runs three sin/cos passes and
//   one vectoring pass per item; the 34x18 multiplier is shared as well.
//   A new item is taken only after the previous one has been loaded into
//   the output register.
//   The result sits in an output register: while the receiver stalls, the
//   next item is still accepted and worked on, and only the final load waits
//   for the register to empty.
//   Reset: registers go to their defaults, the integrator clears, no result
//   is pending.
// ----------------------------------------------------------------------------
module foc_current_loop_svpwm
   import foc_pkg::*;
#(
   parameter int HALF_PERIOD_COUNTS = 2000,
   parameter int CORDIC_STEPS       = 16,
   parameter int SAMPLE_WIDTH       = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_phase_a_current,
   input  logic signed [15:0] req_phase_b_current,
   input  logic [15:0]        req_rotor_angle,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [10:0]        rsp_compare_a,
   output logic [10:0]        rsp_compare_b,
   output logic [10:0]        rsp_compare_c,
   output logic [2:0]         rsp_sector,
   output logic signed [15:0] rsp_iq_measured,
   output logic signed [15:0] rsp_q_voltage,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [3:0]         csr_index,
   input  logic [15:0]        csr_wdata
);

   localparam int N_STEPS = (CORDIC_STEPS < ATAN_COUNT) ? CORDIC_STEPS : ATAN_COUNT;
   localparam int IW      = $clog2(ATAN_COUNT);
   localparam int SW      = SAMPLE_WIDTH;
   localparam int EW      = ((SW > 16) ? SW : 16) + 1;
   localparam int CW      = $clog2(HALF_PERIOD_COUNTS + 1);
   localparam logic signed [63:0] SMAX = (64'sd1 <<< (SW - 1)) - 64'sd1;
   localparam logic signed [63:0] SMIN = -SMAX - 64'sd1;
   localparam logic signed [63:0] T_WIDE = 64'(HALF_PERIOD_COUNTS);

   // sequencer
   foc_state_type state_ff, state_in;
   foc_job_type   job_ff, job_in;
   logic          pass_ff, pass_in;
   logic [IW-1:0] iter_ff, iter_in;

   // item and intermediate values
   logic signed [15:0]   ia_ff, ia_in, ib_ff, ib_in;
   logic [15:0]          ang_ff, ang_in;
   logic signed [33:0]   x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [1:0]           q_ff, q_in;
   logic signed [15:0]   c_ff, c_in, s_ff, s_in, sa_ff, sa_in, sb_ff, sb_in;
   logic signed [SW-1:0] beta_ff, beta_in, iq_ff, iq_in;
   logic signed [EW-1:0] err_ff, err_in;
   logic signed [15:0]   uq_ff, uq_in;
   logic signed [17:0]   ual_ff, ual_in, ube_ff, ube_in;
   logic [28:0]          mag_ff, mag_in;
   logic [2:0]           sec_ff, sec_in;
   logic [31:0]          res_ff, res_in;
   logic signed [32:0]   k_ff, k_in;
   logic signed [51:0]   prod_ff, prod_in;
   logic signed [63:0]   acc_ff, acc_in;
   logic [CW-1:0]        t1_ff, t1_in, t2_ff, t2_in;

   // state and registers
   logic signed [15:0] integ_sum_ff, integ_sum_in;
   logic [15:0]        prop_gain_ff, prop_gain_in, integ_gain_ff, integ_gain_in;
   logic signed [15:0] integ_low_ff, integ_low_in, integ_high_ff, integ_high_in;
   logic signed [15:0] drive_low_ff, drive_low_in, drive_high_ff, drive_high_in;
   logic signed [15:0] iq_target_ff, iq_target_in, d_volt_ff, d_volt_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [10:0]        cmp_a_ff, cmp_a_in, cmp_b_ff, cmp_b_in, cmp_c_ff, cmp_c_in;
   logic [2:0]         rsp_sec_ff, rsp_sec_in;
   logic signed [15:0] rsp_iq_ff, rsp_iq_in, rsp_uq_ff, rsp_uq_in;

   // combinational helpers
   logic               req_take, rsp_load;
   logic [31:0]        rot_ang, rot_sum, rot_rem;
   logic [1:0]         rot_q;
   logic signed [33:0] x_sh, y_sh, atan_v, vx0, vy0;
   logic               dir_sub, iter_last;
   logic signed [34:0] cx_v, sy_v;
   logic signed [15:0] cos_r, sin_r;
   logic signed [33:0] mul_a;
   logic signed [17:0] mul_b;
   logic signed [51:0] mul_p;
   logic signed [63:0] acc_r15, acc_r8, acc_f30, t_r;
   logic signed [EW:0] sum_raw;
   logic [31:0]        phi;
   logic [2:0]         sec_v;
   logic [CW-1:0]      t_sat;
   logic signed [CW+1:0] t0_v;
   logic [CW-1:0]      h_v;
   logic [CW+1:0]      v1_w, v2_w, v3_w;
   logic [CW-1:0]      v0, v1, v2, v3;

   // round a rotator output to q1.15 and saturate
   function automatic logic signed [15:0] rnd_sat16(input logic signed [34:0] v);
      logic signed [34:0] r;
      r = (v + 35'sd16384) >>> 15;
      if (r < -35'sd32768) begin
         return -16'sd32768;
      end else if (r > 35'sd32767) begin
         return 16'sd32767;
      end
      return 16'(r);
   endfunction

   assign req_take  = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_load  = (state_ff == ST_FIN) && !(rsp_valid_ff && rsp_stall);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:     if (req_valid) state_in = ST_ROT_INIT;
         ST_ROT_INIT: state_in = ST_ROT_ITER;
         ST_ROT_ITER: if (iter_last) state_in = ST_ROT_DONE;
         ST_ROT_DONE: begin
            unique case (job_ff)
               JOB_ANG: state_in = ST_BETA_A;
               JOB_SA:  state_in = ST_ROT_INIT;
               JOB_SB:  state_in = ST_ON_K;
               default: state_in = ST_IDLE;
            endcase
         end
         ST_BETA_A:   state_in = ST_BETA_B;
         ST_BETA_B:   state_in = ST_BETA_S;
         ST_BETA_S:   state_in = ST_BETA_F;
         ST_BETA_F:   state_in = ST_IQ_A;
         ST_IQ_A:     state_in = ST_IQ_B;
         ST_IQ_B:     state_in = ST_IQ_S;
         ST_IQ_S:     state_in = ST_IQ_F;
         ST_IQ_F:     state_in = ST_PI_E;
         ST_PI_E:     state_in = ST_PI_A;
         ST_PI_A:     state_in = ST_PI_B;
         ST_PI_B:     state_in = ST_PI_S;
         ST_PI_S:     state_in = ST_PI_F;
         ST_PI_F:     state_in = ST_UA_A;
         ST_UA_A:     state_in = ST_UA_B;
         ST_UA_B:     state_in = ST_UA_S;
         ST_UA_S:     state_in = ST_UA_F;
         ST_UA_F:     state_in = ST_UB_A;
         ST_UB_A:     state_in = ST_UB_B;
         ST_UB_B:     state_in = ST_UB_S;
         ST_UB_S:     state_in = ST_UB_F;
         ST_UB_F:     state_in = ST_VEC_INIT;
         ST_VEC_INIT: state_in = ST_VEC_ITER;
         ST_VEC_ITER: if (iter_last) state_in = ST_MAG_A;
         ST_MAG_A:    state_in = ST_MAG_B;
         ST_MAG_B:    state_in = ST_MAG_S;
         ST_MAG_S:    state_in = ST_MAG_F;
         ST_MAG_F:    state_in = ST_ROT_INIT;
         ST_ON_K:     state_in = ST_ON_A;
         ST_ON_A:     state_in = ST_ON_B;
         ST_ON_B:     state_in = ST_ON_S;
         ST_ON_S:     state_in = ST_ON_C;
         ST_ON_C:     state_in = ST_ON_D;
         ST_ON_D:     state_in = pass_ff ? ST_FIN : ST_ON_K;
         ST_FIN:      if (rsp_load) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // cordic shift-add unit and its angle source
   always_comb begin
      unique case (job_ff)
         JOB_ANG: rot_ang = {ang_ff, 16'h0000};
         JOB_SA:  rot_ang = res_ff;
         JOB_SB:  rot_ang = SECTOR_WIDTH - res_ff;
         default: rot_ang = 32'h0000_0000;
      endcase
      rot_sum   = rot_ang + 32'h2000_0000;
      rot_q     = rot_sum[31:30];
      rot_rem   = rot_ang - {rot_q, 30'd0};
      x_sh      = x_ff >>> iter_ff;
      y_sh      = y_ff >>> iter_ff;
      atan_v    = 34'(atan_angle(5'(iter_ff)));
      dir_sub   = (state_ff == ST_VEC_ITER) ? y_ff[33] : !z_ff[33];
      iter_last = (iter_ff == IW'(N_STEPS - 1));
      vx0       = 34'(ual_ff) <<< 14;
      vy0       = 34'(ube_ff) <<< 14;
      unique case (q_ff)
         2'd0: begin cx_v = 35'(x_ff);  sy_v = 35'(y_ff);  end
         2'd1: begin cx_v = -35'(y_ff); sy_v = 35'(x_ff);  end
         2'd2: begin cx_v = -35'(x_ff); sy_v = -35'(y_ff); end
         default: begin cx_v = 35'(y_ff); sy_v = -35'(x_ff); end
      endcase
      cos_r = rnd_sat16(cx_v);
      sin_r = rnd_sat16(sy_v);
   end

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_BETA_A: begin mul_a = 34'(ia_ff);   mul_b = K_INV_SQRT3; end
         ST_BETA_B: begin mul_a = 34'(ib_ff);   mul_b = K_TWO_INV_SQRT3; end
         ST_IQ_A:   begin mul_a = 34'(beta_ff); mul_b = 18'(c_ff); end
         ST_IQ_B:   begin mul_a = 34'(ia_ff);   mul_b = 18'(s_ff); end
         ST_PI_A:   begin mul_a = 34'(err_ff);  mul_b = {2'b00, prop_gain_ff}; end
         ST_PI_B:   begin mul_a = 34'(integ_sum_ff); mul_b = {2'b00, integ_gain_ff}; end
         ST_UA_A:   begin mul_a = 34'(d_volt_ff); mul_b = 18'(c_ff); end
         ST_UA_B:   begin mul_a = 34'(uq_ff);     mul_b = 18'(s_ff); end
         ST_UB_A:   begin mul_a = 34'(d_volt_ff); mul_b = 18'(s_ff); end
         ST_UB_B:   begin mul_a = 34'(uq_ff);     mul_b = 18'(c_ff); end
         ST_MAG_A:  begin mul_a = GAIN_Q30; mul_b = 18'(x_ff >>> 17); end
         ST_MAG_B:  begin mul_a = GAIN_Q30; mul_b = {1'b0, x_ff[16:0]}; end
         ST_ON_K:   begin mul_a = pass_ff ? 34'(sa_ff) : 34'(sb_ff); mul_b = K_SQRT3; end
         ST_ON_A:   begin mul_a = 34'(signed'(prod_ff[32:0])); mul_b = {4'b0, mag_ff[28:15]}; end
         ST_ON_B:   begin mul_a = 34'(k_ff); mul_b = {3'b000, mag_ff[14:0]}; end
         ST_ON_C:   begin mul_a = 34'(acc_ff >>> 30); mul_b = 18'(HALF_PERIOD_COUNTS); end
         default:   begin mul_a = '0; mul_b = '0; end
      endcase
      mul_p = mul_a * mul_b;
   end

   // rounding, clamps, sector and compare values
   always_comb begin
      acc_r15 = (acc_ff + 64'sd16384) >>> 15;
      acc_r8  = (acc_ff + 64'sd128) >>> 8;
      acc_f30 = acc_ff >>> 30;
      sum_raw = (EW+1)'(integ_sum_ff) + (EW+1)'(err_in);
      phi     = z_ff[31:0];
      priority if (phi >= sector_start(3'd5)) sec_v = 3'd5;
      else if (phi >= sector_start(3'd4)) sec_v = 3'd4;
      else if (phi >= sector_start(3'd3)) sec_v = 3'd3;
      else if (phi >= sector_start(3'd2)) sec_v = 3'd2;
      else if (phi >= sector_start(3'd1)) sec_v = 3'd1;
      else sec_v = 3'd0;
      t_r = (64'(prod_ff) + 64'sd268435456) >>> 29;
      priority if (t_r < 64'sd0) t_sat = '0;
      else if (t_r > T_WIDE) t_sat = CW'(HALF_PERIOD_COUNTS);
      else t_sat = CW'(t_r);
      t0_v = (CW+2)'(HALF_PERIOD_COUNTS) - (CW+2)'(t1_ff) - (CW+2)'(t2_ff);
      h_v  = t0_v[CW+1] ? '0 : CW'(t0_v >>> 1);
      v1_w = (CW+2)'(h_v) + (CW+2)'(t1_ff);
      v2_w = (CW+2)'(h_v) + (CW+2)'(t2_ff);
      v3_w = (CW+2)'(h_v) + (CW+2)'(t1_ff) + (CW+2)'(t2_ff);
      v0 = h_v;
      v1 = (v1_w > (CW+2)'(HALF_PERIOD_COUNTS)) ? CW'(HALF_PERIOD_COUNTS) : CW'(v1_w);
      v2 = (v2_w > (CW+2)'(HALF_PERIOD_COUNTS)) ? CW'(HALF_PERIOD_COUNTS) : CW'(v2_w);
      v3 = (v3_w > (CW+2)'(HALF_PERIOD_COUNTS)) ? CW'(HALF_PERIOD_COUNTS) : CW'(v3_w);
   end

   // datapath register updates
   always_comb begin
      job_in = job_ff;   pass_in = pass_ff;  iter_in = iter_ff;
      ia_in = ia_ff;     ib_in = ib_ff;      ang_in = ang_ff;
      x_in = x_ff;       y_in = y_ff;        z_in = z_ff;       q_in = q_ff;
      c_in = c_ff;       s_in = s_ff;        sa_in = sa_ff;     sb_in = sb_ff;
      beta_in = beta_ff; iq_in = iq_ff;      uq_in = uq_ff;
      ual_in = ual_ff;   ube_in = ube_ff;    mag_in = mag_ff;
      sec_in = sec_ff;   res_in = res_ff;    k_in = k_ff;
      prod_in = prod_ff; acc_in = acc_ff;    t1_in = t1_ff;     t2_in = t2_ff;
      integ_sum_in = integ_sum_ff;
      err_in = EW'(iq_target_ff) - EW'(iq_ff);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               ia_in  = req_phase_a_current;
               ib_in  = req_phase_b_current;
               ang_in = req_rotor_angle;
               job_in = JOB_ANG;
            end
         end
         ST_ROT_INIT: begin
            x_in = GAIN_Q30;
            y_in = '0;
            z_in = 34'(signed'(rot_rem));
            q_in = rot_q;
            iter_in = '0;
         end
         ST_VEC_INIT: begin
            iter_in = '0;
            if (vx0[33]) begin
               x_in = -vx0;
               y_in = -vy0;
               z_in = 34'sh0_8000_0000;
            end else begin
               x_in = vx0;
               y_in = vy0;
               z_in = '0;
            end
         end
         ST_ROT_ITER, ST_VEC_ITER: begin
            iter_in = iter_ff + 1'b1;
            if (dir_sub) begin
               x_in = x_ff - y_sh;
               y_in = y_ff + x_sh;
               z_in = z_ff - atan_v;
            end else begin
               x_in = x_ff + y_sh;
               y_in = y_ff - x_sh;
               z_in = z_ff + atan_v;
            end
         end
         ST_ROT_DONE: begin
            unique case (job_ff)
               JOB_ANG: begin c_in = cos_r; s_in = sin_r; end
               JOB_SA:  begin sa_in = sin_r; job_in = JOB_SB; end
               JOB_SB:  begin sb_in = sin_r; pass_in = 1'b0; end
               default: begin end
            endcase
         end
         ST_BETA_A, ST_IQ_A, ST_PI_A, ST_UA_A, ST_UB_A, ST_MAG_A, ST_ON_K, ST_ON_C: begin
            prod_in = mul_p;
         end
         ST_BETA_B, ST_IQ_B, ST_PI_B, ST_UA_B, ST_UB_B: begin
            acc_in  = 64'(prod_ff);
            prod_in = mul_p;
         end
         ST_BETA_S, ST_PI_S, ST_UB_S, ST_MAG_S, ST_ON_S: acc_in = acc_ff + 64'(prod_ff);
         ST_IQ_S, ST_UA_S: acc_in = acc_ff - 64'(prod_ff);
         ST_BETA_F: begin
            priority if (acc_r15 < SMIN) beta_in = SW'(SMIN);
            else if (acc_r15 > SMAX) beta_in = SW'(SMAX);
            else beta_in = SW'(acc_r15);
         end
         ST_IQ_F: begin
            priority if (acc_r15 < SMIN) iq_in = SW'(SMIN);
            else if (acc_r15 > SMAX) iq_in = SW'(SMAX);
            else iq_in = SW'(acc_r15);
         end
         // error integral with low test first
         ST_PI_E: begin
            priority if (sum_raw < (EW+1)'(integ_low_ff)) integ_sum_in = integ_low_ff;
            else if (sum_raw > (EW+1)'(integ_high_ff)) integ_sum_in = integ_high_ff;
            else integ_sum_in = 16'(sum_raw);
         end
         ST_PI_F: begin
            priority if (acc_r8 < 64'(drive_low_ff)) uq_in = drive_low_ff;
            else if (acc_r8 > 64'(drive_high_ff)) uq_in = drive_high_ff;
            else uq_in = 16'(acc_r8);
         end
         ST_UA_F: ual_in = 18'(acc_r15);
         ST_UB_F: ube_in = 18'(acc_r15);
         ST_MAG_B: begin
            acc_in  = 64'(prod_ff) <<< 17;
            prod_in = mul_p;
         end
         ST_MAG_F: begin
            mag_in = (acc_f30 > VOLT_LIMIT) ? 29'(VOLT_LIMIT) : 29'(acc_f30);
            sec_in = sec_v;
            res_in = phi - sector_start(sec_v);
            job_in = JOB_SA;
         end
         ST_ON_A: begin
            k_in    = prod_ff[32:0];
            prod_in = mul_p;
         end
         ST_ON_B: begin
            acc_in  = 64'(prod_ff) <<< 15;
            prod_in = mul_p;
         end
         ST_ON_D: begin
            if (pass_ff) t2_in = t_sat;
            else t1_in = t_sat;
            pass_in = 1'b1;
         end
         default: begin end
      endcase
   end

   // configuration writes
   always_comb begin
      prop_gain_in  = prop_gain_ff;   integ_gain_in = integ_gain_ff;
      integ_low_in  = integ_low_ff;   integ_high_in = integ_high_ff;
      drive_low_in  = drive_low_ff;   drive_high_in = drive_high_ff;
      iq_target_in  = iq_target_ff;   d_volt_in     = d_volt_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_PROP_GAIN:  prop_gain_in  = csr_wdata;
            REG_INTEG_GAIN: integ_gain_in = csr_wdata;
            REG_INTEG_LOW:  integ_low_in  = signed'(csr_wdata);
            REG_INTEG_HIGH: integ_high_in = signed'(csr_wdata);
            REG_DRIVE_LOW:  drive_low_in  = signed'(csr_wdata);
            REG_DRIVE_HIGH: drive_high_in = signed'(csr_wdata);
            REG_IQ_TARGET:  iq_target_in  = signed'(csr_wdata);
            REG_D_VOLTAGE:  d_volt_in     = signed'(csr_wdata);
            default: begin end
         endcase
      end
   end

   // result register with switching table
   always_comb begin
      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
      cmp_a_in = cmp_a_ff;  cmp_b_in = cmp_b_ff;  cmp_c_in = cmp_c_ff;
      rsp_sec_in = rsp_sec_ff;  rsp_iq_in = rsp_iq_ff;  rsp_uq_in = rsp_uq_ff;
      if (rsp_load) begin
         rsp_sec_in = sec_ff;
         rsp_iq_in  = 16'(iq_ff);
         rsp_uq_in  = uq_ff;
         unique case (sec_ff)
            3'd0: begin cmp_a_in = 11'(v0); cmp_b_in = 11'(v1); cmp_c_in = 11'(v3); end
            3'd1: begin cmp_a_in = 11'(v2); cmp_b_in = 11'(v0); cmp_c_in = 11'(v3); end
            3'd2: begin cmp_a_in = 11'(v3); cmp_b_in = 11'(v0); cmp_c_in = 11'(v1); end
            3'd3: begin cmp_a_in = 11'(v3); cmp_b_in = 11'(v2); cmp_c_in = 11'(v0); end
            3'd4: begin cmp_a_in = 11'(v1); cmp_b_in = 11'(v3); cmp_c_in = 11'(v0); end
            default: begin cmp_a_in = 11'(v0); cmp_b_in = 11'(v3); cmp_c_in = 11'(v2); end
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         job_ff        <= JOB_ANG;
         pass_ff       <= 1'b0;
         iter_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         integ_sum_ff  <= '0;
         prop_gain_ff  <= RST_PROP_GAIN;
         integ_gain_ff <= RST_INTEG_GAIN;
         integ_low_ff  <= RST_LOW_LIMIT;
         integ_high_ff <= RST_HIGH_LIMIT;
         drive_low_ff  <= RST_LOW_LIMIT;
         drive_high_ff <= RST_HIGH_LIMIT;
         iq_target_ff  <= '0;
         d_volt_ff     <= '0;
      end else begin
         state_ff      <= state_in;
         job_ff        <= job_in;
         pass_ff       <= pass_in;
         iter_ff       <= iter_in;
         rsp_valid_ff  <= rsp_valid_in;
         integ_sum_ff  <= integ_sum_in;
         prop_gain_ff  <= prop_gain_in;
         integ_gain_ff <= integ_gain_in;
         integ_low_ff  <= integ_low_in;
         integ_high_ff <= integ_high_in;
         drive_low_ff  <= drive_low_in;
         drive_high_ff <= drive_high_in;
         iq_target_ff  <= iq_target_in;
         d_volt_ff     <= d_volt_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      ia_ff <= ia_in;     ib_ff <= ib_in;     ang_ff <= ang_in;
      x_ff <= x_in;       y_ff <= y_in;       z_ff <= z_in;      q_ff <= q_in;
      c_ff <= c_in;       s_ff <= s_in;       sa_ff <= sa_in;    sb_ff <= sb_in;
      beta_ff <= beta_in; iq_ff <= iq_in;     err_ff <= err_in;  uq_ff <= uq_in;
      ual_ff <= ual_in;   ube_ff <= ube_in;   mag_ff <= mag_in;
      sec_ff <= sec_in;   res_ff <= res_in;   k_ff <= k_in;
      prod_ff <= prod_in; acc_ff <= acc_in;   t1_ff <= t1_in;    t2_ff <= t2_in;
      cmp_a_ff <= cmp_a_in;  cmp_b_ff <= cmp_b_in;  cmp_c_ff <= cmp_c_in;
      rsp_sec_ff <= rsp_sec_in;  rsp_iq_ff <= rsp_iq_in;  rsp_uq_ff <= rsp_uq_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_compare_a   = cmp_a_ff;
   assign rsp_compare_b   = cmp_b_ff;
   assign rsp_compare_c   = cmp_c_ff;
   assign rsp_sector      = rsp_sec_ff;
   assign rsp_iq_measured = rsp_iq_ff;
   assign rsp_q_voltage   = rsp_uq_ff;

   // an accepted item starts with the rotor-angle sin/cos pass
   a_start: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == ST_ROT_INIT && job_ff == JOB_ANG))
      else $error("item did not start the rotor-angle pass");

   // cordic iteration count stays inside the step range
   a_iter: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROT_ITER || state_ff == ST_VEC_ITER) |-> iter_ff <= IW'(N_STEPS - 1))
      else $error("cordic iteration count out of range");

   // the final load always raises the result valid
   a_load: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> rsp_valid)
      else $error("result load lost");

   // sector of a result is one of six
   a_sector: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_sector <= 3'd5)
      else $error("sector out of range");

   // compare counts never pass the half period
   a_cmp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((HALF_PERIOD_COUNTS > 2047) ||
                     (rsp_compare_a <= 11'(HALF_PERIOD_COUNTS) &&
                      rsp_compare_b <= 11'(HALF_PERIOD_COUNTS) &&
                      rsp_compare_c <= 11'(HALF_PERIOD_COUNTS))))
      else $error("compare count above half period");

endmodule
